[rtl/core/wpd_pkg.sv]
package wpd_pkg;

    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int BUDGET_W = 16;
    localparam int WCOUNT_W = 4;
    localparam int WIDX_W   = 3;
    localparam int CFG_W    = 16;
    localparam int OUT_W    = 56;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [WCOUNT_W-1:0] WORKER_COUNT_RESET = 4'd8;

    localparam logic KIND_JOB  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_WORKER_COUNT = 1'b0;
    localparam logic REG_JOB_BUDGET   = 1'b1;

    // Broadcast from the control logic to every worker cell.
    typedef struct packed {
        logic              job;
        logic              tick;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] end_time;
    } t_cell_cmd;

endpackage

[rtl/core/wpd_cell.sv]
module wpd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpd_pkg::t_cell_cmd i_cmd,
    input  logic               i_usable,
    input  logic               i_claim,
    output logic               o_claim,
    output logic               o_grant
);
    import wpd_pkg::*;

    logic              r_busy;
    logic [TIME_W-1:0] r_end_time;
    logic              done;
    logic              free;

    assign done    = r_end_time <= i_cmd.now_time;
    assign free    = i_usable && (!r_busy || done);
    // A free cell claims the job unless a lower cell, or an empty budget, got there first.
    assign o_claim = i_claim | free;
    assign o_grant = i_cmd.job & free & ~i_claim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_grant) begin
            r_busy <= 1'b1;
        end else if (i_cmd.tick && i_usable && r_busy && done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grant) begin
            r_end_time <= i_cmd.end_time;
        end
    end

endmodule

[rtl/core/worker_pool_job_dispatcher.sv]
// Dispatches jobs to a pool of NUM_WORKERS workers, one request per clock cycle. A request
// with tuser 0 is a job (tdata = duration); it goes to the lowest-numbered usable worker
// whose previous job has ended, as long as the job budget is nonzero, and yields one
// result in the next cycle. A request with tuser 1 is a time tick that frees finished workers,
// advances time by one and yields no result. Each worker is a cell in a row; a claim
// signal ripples down the row so the first free cell takes the job in the same cycle.
// A new request is taken whenever the output register is empty or is being read in the
// same cycle, so one request per cycle is sustained while the result side keeps up.
// Writing job_budget reloads the remaining budget; configure only while idle.
module worker_pool_job_dispatcher #(
    parameter int NUM_WORKERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] duration
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // [0] accepted, [3:1] worker_index,
                                          // [35:4] dropped_total, [51:36] budget_remaining
);
    import wpd_pkg::*;

    logic [WCOUNT_W-1:0] r_worker_count;
    logic [BUDGET_W-1:0] r_budget;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_drop_count;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [BUDGET_W-1:0] n_budget;
    logic [TIME_W-1:0]   n_drop_count;
    logic [TIME_W-1:0]   n_now;

    logic                s_accept;
    logic                is_job;
    logic                is_tick;
    logic [TIME_W:0]     end_sum;
    t_cell_cmd           cmd;
    logic [NUM_WORKERS:0]   claim;
    logic [NUM_WORKERS-1:0] grant;
    logic                placed;
    logic [WIDX_W-1:0]   chosen;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign is_job          = s_accept && (i_s_axis_tuser[0] == KIND_JOB);
    assign is_tick         = s_accept && (i_s_axis_tuser[0] == KIND_TICK);

    assign end_sum = {1'b0, r_now} + {{(TIME_W + 1 - DUR_W){1'b0}}, i_s_axis_tdata};

    always_comb begin
        cmd.job      = is_job;
        cmd.tick     = is_tick;
        cmd.now_time = r_now;
        cmd.end_time = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    end

    // An empty budget blocks every cell by entering the row as an existing claim.
    assign claim[0] = (r_budget == '0);

    for (genvar w = 0; w < NUM_WORKERS; w++) begin : g_cell
        logic usable;
        assign usable = 7'(w) < {3'b000, r_worker_count};

        wpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_usable(usable),
            .i_claim (claim[w]),
            .o_claim (claim[w+1]),
            .o_grant (grant[w])
        );
    end

    assign placed = |grant;

    always_comb begin
        chosen = '0;
        for (int w = 0; w < NUM_WORKERS; w++) begin
            if (grant[w]) begin
                chosen = chosen | WIDX_W'(w);
            end
        end
    end

    always_comb begin
        n_budget     = r_budget;
        n_drop_count = r_drop_count;
        if (is_job) begin
            if (placed) begin
                n_budget = r_budget - 1'b1;
            end else if (r_drop_count != TIME_MAX) begin
                n_drop_count = r_drop_count + 1'b1;
            end
        end
        n_now = (r_now != TIME_MAX) ? r_now + 1'b1 : r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= WORKER_COUNT_RESET;
            r_budget       <= '0;
            r_now          <= '0;
            r_drop_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WORKER_COUNT: r_worker_count <= i_cfg_data[WCOUNT_W-1:0];
                    REG_JOB_BUDGET:   r_budget       <= i_cfg_data[BUDGET_W-1:0];
                    default:          r_budget       <= r_budget;
                endcase
            end else begin
                r_budget <= n_budget;
            end
            r_drop_count <= n_drop_count;
            if (is_tick) begin
                r_now <= n_now;
            end
            if (is_job) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_job) begin
            r_out_data <= {4'b0000, n_budget, n_drop_count,
                           placed ? chosen : {WIDX_W{1'b0}}, placed};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant))
        else $error("more than one worker granted the same job");

    a_grant_needs_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        placed |-> (r_budget != '0))
        else $error("job placed with an empty budget");

    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_drop_count >= $past(r_drop_count)))
        else $error("drop count went backward");

    a_drop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_job && !placed) |=> (r_out_valid && !r_out_data[0]))
        else $error("dropped job not reported as dropped");

endmodule

[tb/worker_pool_job_dispatcher_tb.sv]
`timescale 1ns / 1ps

module worker_pool_job_dispatcher_tb;
    import wpd_pkg::*;

    localparam int POOL_SIZE  = 8;
    localparam int HALF_CLK   = 10;
    localparam int LONG_HOLD  = 300;
    localparam int TAIL_WAIT  = 10;

    typedef struct {
        logic                accepted;
        logic [WIDX_W-1:0]   worker;
        logic [TIME_W-1:0]   drops;
        logic [BUDGET_W-1:0] budget;
    } t_dispatch;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // Expected decisions, oldest first.
    t_dispatch decision_q[$];
    int        errors = 0;

    // Mirror of the dispatcher state.
    logic [TIME_W-1:0]   cur_time;
    logic                wk_busy [POOL_SIZE];
    logic [TIME_W-1:0]   wk_end [POOL_SIZE];
    logic [BUDGET_W-1:0] jobs_left;
    logic [TIME_W-1:0]   drop_tally;
    logic [WCOUNT_W-1:0] wcount_reg;

    // Idling controls.
    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;

    worker_pool_job_dispatcher #(
        .NUM_WORKERS(POOL_SIZE)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #HALF_CLK i_clk = ~i_clk;

    // Result side: random short stalls, plus one long hold-off when asked for.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_dispatch want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (decision_q.size() == 0) begin
                $error("result with no request waiting: tdata %h", m_tdata);
                errors++;
            end else begin
                want = decision_q.pop_front();
                if (m_tdata[0] !== want.accepted) begin
                    $error("accepted: expected %0d, actual %0d", want.accepted, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[3:1] !== want.worker) begin
                    $error("worker_index: expected %0d, actual %0d", want.worker,
                           m_tdata[3:1]);
                    errors++;
                end
                if (m_tdata[35:4] !== want.drops) begin
                    $error("dropped_total: expected %0d, actual %0d", want.drops,
                           m_tdata[35:4]);
                    errors++;
                end
                if (m_tdata[51:36] !== want.budget) begin
                    $error("budget_remaining: expected %0d, actual %0d", want.budget,
                           m_tdata[51:36]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("worker_pool_job_dispatcher regression: fail");
        $finish;
    end

    task automatic clear_mirror();
        int w;
        cur_time = '0;
        for (w = 0; w < POOL_SIZE; w++) begin
            wk_busy[w] = 1'b0;
            wk_end[w] = '0;
        end
        jobs_left = '0;
        drop_tally = '0;
        wcount_reg = WORKER_COUNT_RESET;
    endtask

    // Applies one accepted request to the mirror and queues the decision a job yields.
    task automatic dispatch_request(input logic kind, input logic [DUR_W-1:0] dur);
        int        n;
        int        w;
        int        chosen;
        logic [TIME_W:0] sum;
        t_dispatch d;
        n = (wcount_reg > POOL_SIZE) ? POOL_SIZE : int'(wcount_reg);
        if (kind == KIND_TICK) begin
            for (w = 0; w < n; w++) begin
                if (wk_busy[w] && wk_end[w] <= cur_time)
                    wk_busy[w] = 1'b0;
            end
            if (cur_time != TIME_MAX)
                cur_time = cur_time + 1'b1;
        end else begin
            d.accepted = 1'b0;
            chosen = 0;
            if (jobs_left != 0) begin
                for (w = 0; w < n; w++) begin
                    if (!d.accepted && (!wk_busy[w] || wk_end[w] <= cur_time)) begin
                        d.accepted = 1'b1;
                        chosen = w;
                    end
                end
            end
            if (d.accepted) begin
                sum = {1'b0, cur_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
                wk_end[chosen] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                wk_busy[chosen] = 1'b1;
                jobs_left = jobs_left - 1'b1;
            end else if (drop_tally != TIME_MAX) begin
                drop_tally = drop_tally + 1'b1;
            end
            d.worker = d.accepted ? chosen[WIDX_W-1:0] : '0;
            d.drops = drop_tally;
            d.budget = jobs_left;
            decision_q.insert(decision_q.size(), d);
        end
    endtask

    // Offers one request and returns at the edge that takes it, with valid still
    // high unless a gap follows.
    task automatic send_request(input logic kind, input logic [DUR_W-1:0] dur);
        s_tdata <= dur;
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        dispatch_request(kind, dur);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Stops offering requests and waits for every outstanding decision to arrive.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (decision_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_WORKER_COUNT) begin
            wcount_reg = val[WCOUNT_W-1:0];
        end else begin
            jobs_left = val[BUDGET_W-1:0];
        end
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return DUR_W'($urandom_range(0, 12));
        else if (sel < 9)
            return DUR_W'($urandom_range(0, 400));
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic pick_kind(input int tick_pct);
        return ($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_JOB;
    endfunction

    task automatic apply_phase_config(input int sel);
        logic [11:0] junk;
        junk = 12'($urandom);
        case (sel % 6)
            0: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'd8});
                write_reg(REG_JOB_BUDGET, 16'hFFFF);
            end
            1: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'd1});
                write_reg(REG_JOB_BUDGET, 16'($urandom_range(20, 80)));
            end
            2: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'd0});
                write_reg(REG_JOB_BUDGET, 16'hFFFF);
            end
            3: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'd15});
                write_reg(REG_JOB_BUDGET, 16'($urandom_range(0, 3)));
            end
            4: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'($urandom_range(1, 8))});
                write_reg(REG_JOB_BUDGET, 16'($urandom));
            end
            default: begin
                write_reg(REG_WORKER_COUNT, {junk, 4'($urandom_range(0, 15))});
                write_reg(REG_JOB_BUDGET, 16'($urandom_range(0, 200)));
            end
        endcase
    endtask

    // Out of reset the budget is zero, so every job is dropped.
    task automatic test_reset_state();
        send_request(KIND_JOB, 16'h0000);
        send_request(KIND_JOB, 16'hFFFF);
        send_request(KIND_TICK, 16'hA5A5);
    endtask

    // Three workers, budget five: zero and maximum durations, a full pool, a tick
    // after which a worker whose job ends at the new time is reused, and running out of budget.
    task automatic test_dispatch_order();
        write_reg(REG_WORKER_COUNT, 16'd3);
        write_reg(REG_JOB_BUDGET, 16'd5);
        send_request(KIND_JOB, 16'd0);
        send_request(KIND_JOB, 16'hFFFF);
        send_request(KIND_JOB, 16'd1);
        send_request(KIND_JOB, 16'd2);
        send_request(KIND_JOB, 16'd7);
        send_request(KIND_TICK, 16'h5A5A);
        send_request(KIND_JOB, 16'd3);
        send_request(KIND_JOB, 16'd1);
    endtask

    // No usable worker, a count above the pool size, and a single worker.
    task automatic test_worker_count_limits();
        int i;
        write_reg(REG_WORKER_COUNT, 16'hFFF0);
        write_reg(REG_JOB_BUDGET, 16'hFFFF);
        send_request(KIND_JOB, 16'd4);
        write_reg(REG_WORKER_COUNT, 16'h000F);
        for (i = 0; i < 9; i++)
            send_request(KIND_JOB, 16'hFFFF);
        write_reg(REG_WORKER_COUNT, 16'd1);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_JOB, 16'h8001);
    endtask

    task automatic test_random_phases(input int first, input int phases, input int per_phase);
        int p;
        int i;
        int tick_pct;
        for (p = first; p < first + phases; p++) begin
            apply_phase_config(p);
            tick_pct = $urandom_range(10, 60);
            for (i = 0; i < per_phase; i++)
                send_request(pick_kind(tick_pct), pick_duration());
        end
    endtask

    // The result side holds off for a long time while requests keep coming, so the
    // block fills and stops taking input.
    task automatic test_output_stall();
        int i;
        write_reg(REG_WORKER_COUNT, 16'd8);
        write_reg(REG_JOB_BUDGET, 16'hFFFF);
        src_gaps = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_request(pick_kind(20), pick_duration());
        src_gaps = 1'b1;
    endtask

    // The request side pauses mid-stream until every decision has come back.
    task automatic test_pause_for_results();
        int i;
        for (i = 0; i < 30; i++)
            send_request(pick_kind(30), pick_duration());
        settle();
        for (i = 0; i < 30; i++)
            send_request(pick_kind(30), pick_duration());
    endtask

    initial begin
        clear_mirror();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_dispatch_order();
        test_worker_count_limits();
        test_random_phases(0, 10, 160);
        test_output_stall();
        test_pause_for_results();

        // Last stretch runs with both sides always ready.
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_phases(4, 2, 120);

        s_tvalid <= 1'b0;
        while (decision_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("worker_pool_job_dispatcher regression: pass");
        else
            $display("worker_pool_job_dispatcher regression: fail");
        $finish;
    end

endmodule
